@@ sv/sgmo_pkg.sv @@
package sgmo_pkg;

	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_PRESS_TICKS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OSC_PERIOD  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FAST_DUTY   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW_DUTY   = 8'd3;

	localparam logic [15:0] PRESS_TICKS_RST = 16'd50;
	localparam logic [15:0] OSC_PERIOD_RST  = 16'd100;
	localparam logic [15:0] FAST_DUTY_RST   = 16'd200;
	localparam logic [15:0] SLOW_DUTY_RST   = 16'd50;

	localparam logic [15:0] COUNT_MAX = 16'hffff;

	typedef enum logic [1:0] {
		BTN_NONE = 2'd0,
		BTN_MODE = 2'd1,
		BTN_OSC  = 2'd2,
		BTN_BOTH = 2'd3
	} btn_t;

	typedef struct packed {
		logic mode_button_level;
		logic osc_button_level;
		logic sensor_level;
	} tick_t;

	typedef struct packed {
		logic [15:0] down_compare;
		logic [15:0] up_compare;
		logic        relay_on;
		logic        homing_led;
		logic        oscillate_led;
		logic        ready_flag;
	} result_t;

	typedef struct packed {
		logic [15:0] press_ticks;
		logic [15:0] osc_period;
		logic [15:0] fast_duty;
		logic [15:0] slow_duty;
	} cfg_t;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 16'd1;
	endfunction

endpackage

@@ sv/sgmo_core.sv @@
module sgmo_core
	import sgmo_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    advance,
	input  tick_t   tick,
	output result_t result_d
);

	logic [15:0] press_count_q, release_count_q, period_count_q;
	btn_t        latched_q;
	logic        homing_q, osc_en_q, ready_q, running_q, up_phase_q;
	logic [15:0] down_duty_q, up_duty_q;
	logic        relay_q, homing_lamp_q, osc_lamp_q;

	logic [15:0] press_count_d, release_count_d, period_count_d;
	btn_t        latched_d;
	logic        homing_d, osc_en_d, ready_d, running_d, up_phase_d;
	logic [15:0] down_duty_d, up_duty_d;
	logic        relay_d, homing_lamp_d, osc_lamp_d;

	logic        mode_pressed, osc_pressed, sensor;
	logic [15:0] press_inc, release_inc, release_sat, period_inc;

	assign mode_pressed = ~tick.mode_button_level;
	assign osc_pressed  = ~tick.osc_button_level;
	assign sensor       = tick.sensor_level;

	assign press_inc   = sat_inc(press_count_q);
	assign release_inc = sat_inc(release_count_q);
	assign release_sat = (release_inc >= cfg.press_ticks) ? cfg.press_ticks : release_inc;
	assign period_inc  = sat_inc(period_count_q);

	always_comb begin
		press_count_d   = press_count_q;
		release_count_d = release_count_q;
		latched_d       = latched_q;
		homing_d        = homing_q;
		osc_en_d        = osc_en_q;
		ready_d         = ready_q;
		running_d       = running_q;
		up_phase_d      = up_phase_q;
		period_count_d  = period_inc;
		down_duty_d     = down_duty_q;
		up_duty_d       = up_duty_q;
		relay_d         = relay_q;
		homing_lamp_d   = homing_lamp_q;
		osc_lamp_d      = osc_lamp_q;

		// button debounce: held then released for press_ticks each
		if (mode_pressed || osc_pressed) begin
			press_count_d = press_inc;
			if (press_inc >= cfg.press_ticks) begin
				press_count_d = cfg.press_ticks;
				if (mode_pressed && osc_pressed)
					latched_d = BTN_BOTH;
				else if (mode_pressed)
					latched_d = BTN_MODE;
				else
					latched_d = BTN_OSC;
			end
		end else if (press_count_q == cfg.press_ticks) begin
			release_count_d = release_sat;
			if (release_sat == cfg.press_ticks) begin
				if (latched_q == BTN_MODE) begin
					homing_d = osc_en_q ? 1'b0 : ~homing_q;
				end else if (latched_q == BTN_OSC) begin
					osc_en_d = ~osc_en_q;
					homing_d = 1'b0;
					if (osc_en_q) begin
						down_duty_d = '0;
						up_duty_d   = '0;
					end
				end
				press_count_d   = '0;
				release_count_d = '0;
				latched_d       = BTN_NONE;
			end
		end else begin
			press_count_d   = '0;
			release_count_d = '0;
			latched_d       = BTN_NONE;
		end

		// periodic reversal check, phase follows the sensor
		if (period_inc >= cfg.osc_period) begin
			period_count_d = '0;
			if (!running_q) begin
				up_phase_d = 1'b0;
			end else begin
				up_phase_d  = sensor;
				down_duty_d = sensor ? 16'd0 : cfg.slow_duty;
				up_duty_d   = sensor ? cfg.slow_duty : 16'd0;
			end
		end

		if (homing_d && !osc_en_d && !running_q) begin
			homing_lamp_d = 1'b1;
			if (!sensor) begin
				relay_d     = 1'b0;
				down_duty_d = cfg.fast_duty;
				up_duty_d   = '0;
				ready_d     = 1'b0;
			end else begin
				down_duty_d = '0;
				up_duty_d   = '0;
				relay_d     = 1'b1;
				ready_d     = 1'b1;
				homing_d    = 1'b0;
			end
		end else if (!homing_d) begin
			homing_lamp_d = 1'b0;
		end

		if (osc_en_d && !homing_d && !running_q) begin
			if (ready_d) begin
				osc_lamp_d = 1'b1;
				relay_d    = 1'b0;
				running_d  = 1'b1;
				ready_d    = 1'b0;
			end else begin
				osc_en_d   = 1'b0;
				osc_lamp_d = 1'b0;
				running_d  = 1'b0;
			end
		end else if (!osc_en_d && !homing_d) begin
			osc_lamp_d = 1'b0;
			running_d  = 1'b0;
			relay_d    = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_count_q   <= '0;
			release_count_q <= '0;
			period_count_q  <= '0;
			latched_q       <= BTN_NONE;
			homing_q        <= 1'b0;
			osc_en_q        <= 1'b0;
			ready_q         <= 1'b0;
			running_q       <= 1'b0;
			up_phase_q      <= 1'b0;
			down_duty_q     <= '0;
			up_duty_q       <= '0;
			relay_q         <= 1'b1;
			homing_lamp_q   <= 1'b0;
			osc_lamp_q      <= 1'b0;
		end else if (advance) begin
			press_count_q   <= press_count_d;
			release_count_q <= release_count_d;
			period_count_q  <= period_count_d;
			latched_q       <= latched_d;
			homing_q        <= homing_d;
			osc_en_q        <= osc_en_d;
			ready_q         <= ready_d;
			running_q       <= running_d;
			up_phase_q      <= up_phase_d;
			down_duty_q     <= down_duty_d;
			up_duty_q       <= up_duty_d;
			relay_q         <= relay_d;
			homing_lamp_q   <= homing_lamp_d;
			osc_lamp_q      <= osc_lamp_d;
		end
	end

	assign result_d.down_compare  = down_duty_d;
	assign result_d.up_compare    = up_duty_d;
	assign result_d.relay_on      = relay_d;
	assign result_d.homing_led    = homing_lamp_d;
	assign result_d.oscillate_led = osc_lamp_d;
	assign result_d.ready_flag    = ready_d;

endmodule

@@ sv/sensor_guided_motor_oscillator_top.sv @@
// Motor oscillator control, one tick beat in, one result beat out. Each accepted tick
// (two active-low button levels and the sensor level) updates the debounce counters,
// the period counter and the homing/oscillation state; the resulting PWM compares,
// relay enable and lamps are written into a two-entry result queue and leave it in
// order on the result channel. A tick can be accepted in every cycle while tick_stall
// is low: control state, configuration registers and the queue are the only storage,
// so tick_stall rises only once two results are waiting, and falls as soon as one is
// taken. Configuration writes are always ready and take effect from the next tick.
module sensor_guided_motor_oscillator_top
	import sgmo_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tick_valid,
	output logic                 tick_stall,
	input  tick_t                tick,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]          cfg_data
);

	cfg_t    cfg_q;
	result_t result_d;
	result_t queue_q [2];
	logic    wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic    push, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_ticks <= PRESS_TICKS_RST;
			cfg_q.osc_period  <= OSC_PERIOD_RST;
			cfg_q.fast_duty   <= FAST_DUTY_RST;
			cfg_q.slow_duty   <= SLOW_DUTY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PRESS_TICKS: cfg_q.press_ticks <= cfg_data;
				CFG_OSC_PERIOD:  cfg_q.osc_period  <= cfg_data;
				CFG_FAST_DUTY:   cfg_q.fast_duty   <= cfg_data;
				CFG_SLOW_DUTY:   cfg_q.slow_duty   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign tick_stall = (count_q == 2'd2);
	assign push       = tick_valid && !tick_stall;
	assign pop        = result_valid && !result_stall;

	sgmo_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.advance  (push),
		.tick     (tick),
		.result_d (result_d)
	);

	always_ff @(posedge clk) begin
		if (push)
			queue_q[wr_ptr_q] <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	assign result_valid = (count_q != 2'd0);
	assign result       = queue_q[rd_ptr_q];

endmodule

@@ sv/sgmo_checker.sv @@
module sgmo_checker
	import sgmo_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_stall,
	input result_t              result
);

	// a waiting result beat holds until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// running clears ready, and ready is only set while not running
	a_ready_not_running: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.ready_flag && result.oscillate_led))
		else $error("ready flag set while oscillating");

	a_lamps_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.homing_led && result.oscillate_led))
		else $error("homing and oscillation lamps both lit");

	// relays stay off for the whole oscillation run
	a_relay_off_running: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.oscillate_led |-> !result.relay_on)
		else $error("relay on while oscillating");

	// after homing completes the motor is parked until oscillation starts
	a_ready_parked: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.ready_flag |->
			result.down_compare == 16'd0 && result.up_compare == 16'd0)
		else $error("motor driven while ready");

endmodule

bind sensor_guided_motor_oscillator_top sgmo_checker u_sgmo_checker (.*);
